/* design/raster_conv3x3_zero_pad_macros.svh */
// Assertion macros shared by the 3x3 raster filter.
// Needs nothing else; the user supplies clock, active-low reset and the message.
`ifndef RASTER_CONV3X3_ZERO_PAD_MACROS_SVH
`define RASTER_CONV3X3_ZERO_PAD_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RC3_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RC3_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rc3_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and register codes of the 3x3 raster filter.
// Depends on nothing; every module of the block imports it.
package rc3_pkg;

    localparam int PIXEL_WIDTH  = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int COEF_FRAC    = 12;
    localparam int PROD_W       = PIXEL_WIDTH + COEF_WIDTH;
    localparam int ROW_SUM_W    = PROD_W + 2;
    localparam int ACC_W        = PROD_W + 4;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 1024;

    localparam int SIZE_W       = 11;
    localparam int SIZE_RESET   = 1024;
    localparam int WEIGHT_W     = 3 * COEF_WIDTH;
    localparam int CFG_DATA_W   = WEIGHT_W;
    localparam int CFG_IDX_W    = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_LEFT_RESET   = '0;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CENTER_RESET = 48'h0000_1000_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RIGHT_RESET  = '0;

    localparam int ROW_FIELD_W  = 10;
    localparam int COL_FIELD_W  = 10;

    localparam int FIFO_DEPTH   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_COUNT      = 3'd0,
        CFG_ROW_COUNT      = 3'd1,
        CFG_WEIGHTS_LEFT   = 3'd2,
        CFG_WEIGHTS_CENTER = 3'd3,
        CFG_WEIGHTS_RIGHT  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_DRAIN = 1'b1
    } req_kind_t;

    typedef logic signed [PIXEL_WIDTH-1:0] pixel_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef pixel_t     [2:0] pixel_row_t;
    typedef pixel_row_t [2:0] window_t;
    typedef coef_t      [2:0] coef_row_t;
    typedef coef_row_t  [2:0] coef_grid_t;

    typedef struct packed {
        logic [0:0] req_type;
        pixel_t     pixel;
    } in_beat_t;

    typedef struct packed {
        pixel_t                 value;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic                   last;
    } out_beat_t;

    // One line-store entry: the two previous columns at one row.
    typedef struct packed {
        pixel_t older;
        pixel_t prev;
    } entry_t;

    // Position and border flags of the output that an item releases.
    typedef struct packed {
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic                   last;
        logic                   up_ok;
        logic                   down_ok;
        logic                   left_ok;
        logic                   right_ok;
    } meta_t;

    typedef struct packed {
        logic   valid;
        logic   result;
        pixel_t px;
    } store_req_t;

endpackage

/* design/rc3_col_store.sv */
`timescale 1ns / 1ps
// Column line store with read-modify-write and the 3x3 window registers.
// Depends on rc3_pkg.
module rc3_col_store #(
    parameter int MAX_ROWS = rc3_pkg::MAX_ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rc3_pkg::store_req_t         req_i,
    input  logic [$clog2(MAX_ROWS)-1:0] addr_i,
    input  rc3_pkg::meta_t              meta_i,
    output logic                        win_valid_o,
    output rc3_pkg::meta_t              win_meta_o,
    output rc3_pkg::window_t            win_o
);
    import rc3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROWS);

    entry_t              mem [MAX_ROWS];
    entry_t              rd_data_reg;
    entry_t              byp_data_reg;
    logic                byp_hit_reg;
    entry_t              cur_entry;
    entry_t              wr_data;

    logic                s1_valid_reg;
    logic                s1_result_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    pixel_t              s1_px_reg;
    meta_t               s1_meta_reg;

    window_t             win_reg;
    logic                win_valid_reg;
    meta_t               win_meta_reg;

    // The previous beat writes its row at the same edge as this read; when the
    // rows match (one-row images) its write data is taken instead.
    assign cur_entry = byp_hit_reg ? byp_data_reg : rd_data_reg;

    always_comb begin
        wr_data.older = cur_entry.prev;
        wr_data.prev  = s1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= wr_data;
        end
        if (req_i.valid) begin
            rd_data_reg <= mem[addr_i];
        end
    end

    always_ff @(posedge aclk) begin
        if (req_i.valid) begin
            byp_hit_reg   <= s1_valid_reg && (s1_addr_reg == addr_i);
            byp_data_reg  <= wr_data;
            s1_addr_reg   <= addr_i;
            s1_px_reg     <= req_i.px;
            s1_meta_reg   <= meta_i;
            s1_result_reg <= req_i.result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= req_i.valid;
            win_valid_reg <= s1_valid_reg && s1_result_reg;
        end
    end

    // Window moves down one row; the new bottom row is the older column, the
    // previous column and the incoming pixel.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= cur_entry.older;
            win_reg[2][1] <= cur_entry.prev;
            win_reg[2][2] <= s1_px_reg;
            win_meta_reg  <= s1_meta_reg;
        end
    end

    assign win_valid_o = win_valid_reg;
    assign win_meta_o  = win_meta_reg;
    assign win_o       = win_reg;

endmodule

/* design/rc3_mac.sv */
`timescale 1ns / 1ps
// Nine masked products, an adder tree over two stages, rounding and saturation.
// Depends on rc3_pkg.
module rc3_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          win_valid_i,
    input  rc3_pkg::meta_t                win_meta_i,
    input  rc3_pkg::window_t              win_i,
    input  logic [rc3_pkg::WEIGHT_W-1:0]  weights_left_i,
    input  logic [rc3_pkg::WEIGHT_W-1:0]  weights_center_i,
    input  logic [rc3_pkg::WEIGHT_W-1:0]  weights_right_i,
    output logic                          res_valid_o,
    output rc3_pkg::out_beat_t            res_o
);
    import rc3_pkg::*;

    localparam int Q_W = ACC_W - COEF_FRAC;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));
    localparam logic signed [Q_W-1:0]   SAT_MAX    = Q_W'((2 ** (PIXEL_WIDTH - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_MIN    = Q_W'(-(2 ** (PIXEL_WIDTH - 1)));

    coef_grid_t                 coef;
    logic [2:0]                 row_ok;
    logic [2:0]                 col_ok;
    logic signed [PROD_W-1:0]   mul [3][3];
    logic signed [PROD_W-1:0]   prod_next [3][3];
    logic signed [PROD_W-1:0]   prod_reg [3][3];
    logic                       a_valid_reg;
    meta_t                      a_meta_reg;

    logic signed [ROW_SUM_W-1:0] row_sum_next [3];
    logic signed [ROW_SUM_W-1:0] row_sum_reg [3];
    logic                        b_valid_reg;
    meta_t                       b_meta_reg;

    logic signed [ACC_W-1:0]     acc;
    logic signed [Q_W-1:0]       quot;
    pixel_t                      value_sat;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef[r][0] = coef_t'(weights_left_i[r*COEF_WIDTH +: COEF_WIDTH]);
            coef[r][1] = coef_t'(weights_center_i[r*COEF_WIDTH +: COEF_WIDTH]);
            coef[r][2] = coef_t'(weights_right_i[r*COEF_WIDTH +: COEF_WIDTH]);
        end
    end

    // Bit 0 is the upper or left neighbour, bit 2 the lower or right one.
    assign row_ok = {win_meta_i.down_ok, 1'b1, win_meta_i.up_ok};
    assign col_ok = {win_meta_i.right_ok, 1'b1, win_meta_i.left_ok};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mul[r][c]       = $signed(coef[r][c]) * $signed(win_i[r][c]);
                prod_next[r][c] = (row_ok[r] && col_ok[c]) ? mul[r][c] : PROD_W'(0);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum_next[r] = ROW_SUM_W'(prod_reg[r][0]) + ROW_SUM_W'(prod_reg[r][1])
                            + ROW_SUM_W'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (win_valid_i) begin
            prod_reg   <= prod_next;
            a_meta_reg <= win_meta_i;
        end
        if (a_valid_reg) begin
            row_sum_reg <= row_sum_next;
            b_meta_reg  <= a_meta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= win_valid_i;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Adding half an LSB and shifting arithmetically rounds ties upwards.
    always_comb begin
        acc  = ACC_W'(row_sum_reg[0]) + ACC_W'(row_sum_reg[1]) + ACC_W'(row_sum_reg[2])
             + ROUND_HALF;
        quot = acc[ACC_W-1:COEF_FRAC];
        priority if (quot > SAT_MAX) begin
            value_sat = PIXEL_WIDTH'(SAT_MAX);
        end else if (quot < SAT_MIN) begin
            value_sat = PIXEL_WIDTH'(SAT_MIN);
        end else begin
            value_sat = PIXEL_WIDTH'(quot);
        end
    end

    always_comb begin
        res_o.value = value_sat;
        res_o.row   = b_meta_reg.row;
        res_o.col   = b_meta_reg.col;
        res_o.last  = b_meta_reg.last;
    end

    assign res_valid_o = b_valid_reg;

endmodule

/* design/rc3_out_fifo.sv */
`timescale 1ns / 1ps
// Small result queue that decouples the filter pipeline from the output beat.
// Depends on rc3_pkg; overflow is prevented by the credit count at the top level.
module rc3_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_i,
    input  rc3_pkg::out_beat_t push_data_i,
    input  logic               pop_i,
    output logic               valid_o,
    output rc3_pkg::out_beat_t data_o
);
    import rc3_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    out_beat_t         fifo_q [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_ff @(posedge aclk) begin
        if (push_i) begin
            fifo_q[wr_ptr_reg] <= push_data_i;
        end
    end

    always_comb begin
        unique case ({push_i, pop_i})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop_i) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign valid_o = count_reg != '0;
    assign data_o  = fifo_q[rd_ptr_reg];

endmodule

/* design/raster_conv3x3_zero_pad.sv */
`timescale 1ns / 1ps
// Top level of the 3x3 zero-padded raster filter: configuration, raster counters,
// credit control and assertions. Depends on rc3_pkg, rc3_col_store, rc3_mac,
// rc3_out_fifo and raster_conv3x3_zero_pad_macros.svh.
//
//  Channel   Ports                             Beat
//  --------  --------------------------------  -----------------------------------
//  input     s_valid, s_ready, s_beat          req_type, pixel (column-major)
//  result    m_valid, m_ready, m_beat          value, row, col, last
//  config    cfg_wr_en, cfg_index, cfg_wr_data write only, no wait
//
// One input beat is taken every cycle while s_ready is high; each result goes
// through store read, window, products, adder tree and output queue to m_valid.
// s_ready falls only when eight results are in flight or queued, the depth of
// the output queue. The line store needs no clearing pass; reset is synchronous.
// Writing a size register restarts the image.
`include "raster_conv3x3_zero_pad_macros.svh"

module raster_conv3x3_zero_pad #(
    parameter int MAX_ROWS = rc3_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = rc3_pkg::MAX_COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rc3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rc3_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rc3_pkg::in_beat_t              s_beat,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rc3_pkg::out_beat_t             m_beat
);
    import rc3_pkg::*;

    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int ROW_SZ_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int COL_SZ_W  = $clog2(MAX_COLS + 1);
    localparam int COL_CNT_W = $clog2(MAX_COLS + 2);
    localparam int OCC_W     = $clog2(FIFO_DEPTH + 1);
    localparam int NR_RESET  = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;
    localparam int NC_RESET  = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;

    // Configuration.
    logic [SIZE_W-1:0]    size_raw;
    logic [ROW_SZ_W-1:0]  nr_wr;
    logic [COL_SZ_W-1:0]  nc_wr;
    logic [ROW_SZ_W-1:0]  nr_reg;
    logic [COL_SZ_W-1:0]  nc_reg;
    logic [WEIGHT_W-1:0]  weights_left_reg;
    logic [WEIGHT_W-1:0]  weights_center_reg;
    logic [WEIGHT_W-1:0]  weights_right_reg;
    logic                 size_restart;

    // Raster counters.
    logic [ROW_IDX_W-1:0] in_row_reg,  in_row_next;
    logic [COL_CNT_W-1:0] in_col_reg,  in_col_next;
    logic [ROW_IDX_W-1:0] out_row_reg, out_row_next;
    logic [COL_IDX_W-1:0] out_col_reg, out_col_next;

    logic                 accept;
    logic                 loading;
    logic                 drain_req;
    logic                 step;
    logic                 pending;
    logic                 result_step;
    logic                 row_wrap;
    logic                 out_row_last;
    logic                 out_col_last;
    logic                 last_out;

    store_req_t           store_req;
    meta_t                meta;

    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic                 pop;

    logic                 win_valid;
    meta_t                win_meta;
    window_t              win;
    logic                 res_valid;
    out_beat_t            res;

    // Sizes are clamped once, when written: zero acts as one, overlarge as the maximum.
    assign size_raw = cfg_wr_data[SIZE_W-1:0];

    always_comb begin
        priority if (size_raw == '0) begin
            nr_wr = ROW_SZ_W'(1);
        end else if (int'(size_raw) > MAX_ROWS) begin
            nr_wr = ROW_SZ_W'(MAX_ROWS);
        end else begin
            nr_wr = ROW_SZ_W'(size_raw);
        end
    end

    always_comb begin
        priority if (size_raw == '0) begin
            nc_wr = COL_SZ_W'(1);
        end else if (int'(size_raw) > MAX_COLS) begin
            nc_wr = COL_SZ_W'(MAX_COLS);
        end else begin
            nc_wr = COL_SZ_W'(size_raw);
        end
    end

    assign size_restart = cfg_wr_en
                       && (cfg_index == CFG_COL_COUNT || cfg_index == CFG_ROW_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nr_reg             <= ROW_SZ_W'(NR_RESET);
            nc_reg             <= COL_SZ_W'(NC_RESET);
            weights_left_reg   <= WEIGHT_LEFT_RESET;
            weights_center_reg <= WEIGHT_CENTER_RESET;
            weights_right_reg  <= WEIGHT_RIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COL_COUNT:      nc_reg             <= nc_wr;
                CFG_ROW_COUNT:      nr_reg             <= nr_wr;
                CFG_WEIGHTS_LEFT:   weights_left_reg   <= cfg_wr_data[WEIGHT_W-1:0];
                CFG_WEIGHTS_CENTER: weights_center_reg <= cfg_wr_data[WEIGHT_W-1:0];
                CFG_WEIGHTS_RIGHT:  weights_right_reg  <= cfg_wr_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // A drain beat while pixels are still expected is taken and dropped.
    assign accept      = s_valid && s_ready;
    assign loading     = in_col_reg < COL_CNT_W'(nc_reg);
    assign drain_req   = s_beat.req_type == REQ_DRAIN;
    assign step        = accept && !(drain_req && loading);
    assign pending     = (in_col_reg >= COL_CNT_W'(2))
                      || ((in_col_reg == COL_CNT_W'(1)) && (in_row_reg != '0));
    assign result_step = step && pending;

    assign row_wrap     = (ROW_SZ_W'(in_row_reg) + ROW_SZ_W'(1)) == nr_reg;
    assign out_row_last = (ROW_SZ_W'(out_row_reg) + ROW_SZ_W'(1)) == nr_reg;
    assign out_col_last = (COL_SZ_W'(out_col_reg) + COL_SZ_W'(1)) == nc_reg;
    assign last_out     = out_row_last && out_col_last;

    always_comb begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        priority if (size_restart || (result_step && last_out)) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end else if (step) begin
            if (row_wrap) begin
                in_row_next = '0;
                in_col_next = in_col_reg + COL_CNT_W'(1);
            end else begin
                in_row_next = in_row_reg + ROW_IDX_W'(1);
            end
            if (pending) begin
                if (out_row_last) begin
                    out_row_next = '0;
                    out_col_next = out_col_reg + COL_IDX_W'(1);
                end else begin
                    out_row_next = out_row_reg + ROW_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    always_comb begin
        store_req.valid  = step;
        store_req.result = pending;
        store_req.px     = loading ? s_beat.pixel : PIXEL_WIDTH'(0);
        meta.row         = ROW_FIELD_W'(out_row_reg);
        meta.col         = COL_FIELD_W'(out_col_reg);
        meta.last        = last_out;
        meta.up_ok       = out_row_reg != '0;
        meta.down_ok     = !out_row_last;
        meta.left_ok     = out_col_reg != '0;
        meta.right_ok    = !out_col_last;
    end

    // Credit: every result accepted but not yet delivered holds a queue slot.
    assign pop = m_valid && m_ready;

    always_comb begin
        unique case ({result_step, pop})
            2'b10:   occ_next = occ_reg + OCC_W'(1);
            2'b01:   occ_next = occ_reg - OCC_W'(1);
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign s_ready = occ_reg < OCC_W'(FIFO_DEPTH);

    rc3_col_store #(
        .MAX_ROWS (MAX_ROWS)
    ) u_col_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_i       (store_req),
        .addr_i      (in_row_reg),
        .meta_i      (meta),
        .win_valid_o (win_valid),
        .win_meta_o  (win_meta),
        .win_o       (win)
    );

    rc3_mac u_mac (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .win_valid_i      (win_valid),
        .win_meta_i       (win_meta),
        .win_i            (win),
        .weights_left_i   (weights_left_reg),
        .weights_center_i (weights_center_reg),
        .weights_right_i  (weights_right_reg),
        .res_valid_o      (res_valid),
        .res_o            (res)
    );

    rc3_out_fifo u_out_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (res_valid),
        .push_data_i (res),
        .pop_i       (pop),
        .valid_o     (m_valid),
        .data_o      (m_beat)
    );

    `RC3_ASSERT_SAME(a_result_has_credit, aclk, aresetn, m_valid, occ_reg != '0, "result beat without credit")
    `RC3_ASSERT_SAME(a_row_in_range, aclk, aresetn, 1'b1, ROW_SZ_W'(in_row_reg) < nr_reg, "input row beyond image height")
    `RC3_ASSERT_NEXT(a_early_drain_idle, aclk, aresetn, accept && drain_req && loading && !cfg_wr_en, $stable(in_row_reg) && $stable(in_col_reg) && $stable(out_row_reg), "early drain changed the raster position")
    `RC3_ASSERT_NEXT(a_last_restarts, aclk, aresetn, result_step && last_out, (in_col_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0), "image did not restart after its last pixel")

endmodule
